/* rtl/core/fah_pkg.sv */
// fah_pkg: shared types, register codes and fuzzy set tables for the
// obstacle avoidance heading core. No dependencies.
package fah_pkg;

  localparam int ANGLE_SETS = 7;
  localparam int DIST_SETS  = 5;
  localparam int ONE_Q12    = 4096;

  typedef struct packed {
    logic signed [15:0] obstacle_angle;
    logic        [15:0] obstacle_distance;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] heading_turn;
    logic               no_rule_fired;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_DIST_MAX  = 2'd0,
    REG_ANGLE_MAX = 2'd1,
    REG_TURN_MAX  = 2'd2
  } reg_idx_t;

  // breakpoints (foot, apex, foot) in whole units
  localparam int ANGLE_PTS [ANGLE_SETS][3] = '{
    '{-3, -3, -2}, '{-3, -2, -1}, '{-2, -1, 0}, '{-1, 0, 1},
    '{0, 1, 2}, '{1, 2, 3}, '{2, 3, 3}
  };

  localparam int DIST_PTS [DIST_SETS][3] = '{
    '{-4, -4, -2}, '{-4, -2, 0}, '{-2, 0, 2}, '{0, 2, 4}, '{2, 4, 4}
  };

  localparam logic signed [2:0] RULE_TAB [ANGLE_SETS][DIST_SETS] = '{
    '{ 3'sd1,  3'sd0,  3'sd0,  3'sd0, 3'sd0},
    '{ 3'sd1,  3'sd1,  3'sd0,  3'sd0, 3'sd0},
    '{ 3'sd2,  3'sd2,  3'sd1,  3'sd0, 3'sd0},
    '{-3'sd3, -3'sd3, -3'sd2, -3'sd1, 3'sd0},
    '{-3'sd2, -3'sd2, -3'sd1,  3'sd0, 3'sd0},
    '{-3'sd1, -3'sd1,  3'sd0,  3'sd0, 3'sd0},
    '{-3'sd1,  3'sd0,  3'sd0,  3'sd0, 3'sd0}
  };

  // triangular membership in Q1.12; slopes are one or two units wide
  function automatic logic [12:0] member(logic signed [15:0] x, int a, int b, int c);
    logic signed [18:0] xs;
    logic signed [18:0] lo;
    logic signed [18:0] ap;
    logic signed [18:0] hi;
    logic signed [18:0] t;
    logic [12:0]        res;
    xs  = 19'(x);
    lo  = 19'(a * ONE_Q12);
    ap  = 19'(b * ONE_Q12);
    hi  = 19'(c * ONE_Q12);
    res = '0;
    if (xs >= lo && xs <= ap) begin
      if (a == b) begin
        res = 13'(ONE_Q12);
      end else begin
        t   = xs - lo;
        res = ((b - a) == 2) ? t[13:1] : t[12:0];
      end
    end else if (xs > ap && xs <= hi) begin
      t   = hi - xs;
      res = ((c - b) == 2) ? t[13:1] : t[12:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/fah_div.sv */
// fah_div: pipelined restoring divider, one quotient bit per stage, with
// an overflow flag when the quotient does not fit. Standalone module.
module fah_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_sb,
  output logic          out_vld,
  output logic [QW-1:0] out_q,
  output logic          out_ovf,
  output logic [SW-1:0] out_sb
);

  logic          vld_r [QW+1];
  logic [DW-1:0] rem_r [QW+1];
  logic [DW-1:0] d_r   [QW+1];
  logic [QW-1:0] lo_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          ovf_r [QW+1];
  logic [SW-1:0] sb_r  [QW+1];

  logic [NW-1:0] hi_part;
  assign hi_part = in_num >> QW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 0; k < QW; k++) vld_r[k+1] <= vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    logic [DW:0] t;
    logic [DW:0] diff;
    if (en) begin
      rem_r[0] <= hi_part[DW-1:0];
      d_r[0]   <= in_den;
      lo_r[0]  <= in_num[QW-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= (hi_part >= NW'(in_den));
      sb_r[0]  <= in_sb;
      for (int k = 0; k < QW; k++) begin
        t    = {rem_r[k], lo_r[k][QW-1]};
        diff = t - {1'b0, d_r[k]};
        if (t >= {1'b0, d_r[k]}) begin
          rem_r[k+1] <= diff[DW-1:0];
          q_r[k+1]   <= {q_r[k][QW-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= t[DW-1:0];
          q_r[k+1]   <= {q_r[k][QW-2:0], 1'b0};
        end
        d_r[k+1]   <= d_r[k];
        lo_r[k+1]  <= {lo_r[k][QW-2:0], 1'b0};
        ovf_r[k+1] <= ovf_r[k];
        sb_r[k+1]  <= sb_r[k];
      end
    end
  end

  assign out_vld = vld_r[QW];
  assign out_q   = q_r[QW];
  assign out_ovf = ovf_r[QW];
  assign out_sb  = sb_r[QW];

endmodule

/* rtl/core/fuzzy_avoid_heading_core.sv */
// Fuzzy obstacle avoidance heading core. Takes one item per clock cycle
// when the result side does not stall: two 17-stage dividers scale angle
// and distance, five stages fuzzify, weigh and sum the rule table, and a
// further 17-stage divider forms the weighted average.
// A stall on the result side holds the whole pipeline, nothing is lost.
// Depends on fah_pkg and fah_div.
module fuzzy_avoid_heading_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fah_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output fah_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);

  localparam int NA = fah_pkg::ANGLE_SETS;
  localparam int ND = fah_pkg::DIST_SETS;

  logic [15:0] dist_max_r;
  logic [14:0] angle_max_r;
  logic [14:0] turn_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_max_r  <= 16'd1000;
      angle_max_r <= 15'd90;
      turn_max_r  <= 15'd30;
    end else if (cfg_we) begin
      unique case (fah_pkg::reg_idx_t'(cfg_index))
        fah_pkg::REG_DIST_MAX:  dist_max_r  <= cfg_wdata;
        fah_pkg::REG_ANGLE_MAX: angle_max_r <= cfg_wdata[14:0];
        fah_pkg::REG_TURN_MAX:  turn_max_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // input scaling
  logic        aneg;
  logic [15:0] amag;
  logic [29:0] a_num;
  logic [28:0] d_num;
  logic [14:0] a_den;
  logic [15:0] d_den;

  assign aneg  = in_item.obstacle_angle[15];
  assign amag  = aneg ? 16'(-in_item.obstacle_angle) : in_item.obstacle_angle;
  assign a_num = {1'b0, amag, 13'b0} + {2'b0, amag, 12'b0};
  assign d_num = {in_item.obstacle_distance, 13'b0};
  assign a_den = (angle_max_r == '0) ? 15'd1 : angle_max_r;
  assign d_den = (dist_max_r == '0) ? 16'd1 : dist_max_r;

  logic        a_vld, d_vld, a_ovf, d_ovf, a_sb, d_sb;
  logic [15:0] a_q, d_q;

  fah_div #(.NW(30), .DW(15), .QW(16), .SW(1)) u_adiv (
    .clk, .rst_n, .en,
    .in_vld(in_valid && en), .in_num(a_num), .in_den(a_den), .in_sb(aneg),
    .out_vld(a_vld), .out_q(a_q), .out_ovf(a_ovf), .out_sb(a_sb)
  );

  fah_div #(.NW(29), .DW(16), .QW(16), .SW(1)) u_ddiv (
    .clk, .rst_n, .en,
    .in_vld(in_valid && en), .in_num(d_num), .in_den(d_den), .in_sb(aneg),
    .out_vld(d_vld), .out_q(d_q), .out_ovf(d_ovf), .out_sb(d_sb)
  );

  // saturate into Q4.12
  logic [16:0]        a_mag;
  logic [16:0]        a_cap;
  logic signed [15:0] ax;
  logic signed [15:0] dx;

  always_comb begin
    a_mag = a_ovf ? 17'd32768 : {1'b0, a_q};
    if (a_sb) begin
      a_cap = (a_mag > 17'd32768) ? 17'd32768 : a_mag;
      ax    = 16'(-a_cap);
    end else begin
      a_cap = (a_mag > 17'd32767) ? 17'd32767 : a_mag;
      ax    = a_cap[15:0];
    end
    dx = (d_ovf || d_q > 16'd32767) ? 16'sd32767 : d_q;
  end

  // fuzzify
  logic        m_vld_r;
  logic [12:0] ua_r [NA];
  logic [12:0] ud_r [ND];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++)
        ua_r[i] <= fah_pkg::member(ax, fah_pkg::ANGLE_PTS[i][0],
                                   fah_pkg::ANGLE_PTS[i][1], fah_pkg::ANGLE_PTS[i][2]);
      for (int j = 0; j < ND; j++)
        ud_r[j] <= fah_pkg::member(dx, fah_pkg::DIST_PTS[j][0],
                                   fah_pkg::DIST_PTS[j][1], fah_pkg::DIST_PTS[j][2]);
    end
  end

  // rule rows against distance memberships, and membership sums
  logic               r_vld_r;
  logic signed [17:0] rr_r  [NA];
  logic [12:0]        ua2_r [NA];
  logic [13:0]        sua_r, sud_r;

  always_ff @(posedge clk) begin
    logic signed [17:0] acc;
    logic [13:0]        sa, sd;
    if (en) begin
      sa = '0;
      sd = '0;
      for (int i = 0; i < NA; i++) begin
        acc = '0;
        for (int j = 0; j < ND; j++)
          acc = acc + 18'(fah_pkg::RULE_TAB[i][j]) * 18'($signed({1'b0, ud_r[j]}));
        rr_r[i]  <= acc;
        ua2_r[i] <= ua_r[i];
        sa = sa + 14'(ua_r[i]);
      end
      for (int j = 0; j < ND; j++) sd = sd + 14'(ud_r[j]);
      sua_r <= sa;
      sud_r <= sd;
    end
  end

  // products
  logic               p_vld_r;
  logic signed [30:0] p_r [NA];
  logic [27:0]        den_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++)
        p_r[i] <= 31'($signed({1'b0, ua2_r[i]})) * 31'(rr_r[i]);
      den_r <= 28'(sua_r) * 28'(sud_r);
    end
  end

  // weighted sum
  logic               s_vld_r;
  logic signed [33:0] num_r;
  logic [27:0]        den2_r;

  always_ff @(posedge clk) begin
    logic signed [33:0] acc;
    if (en) begin
      acc = '0;
      for (int i = 0; i < NA; i++) acc = acc + 34'(p_r[i]);
      num_r  <= acc;
      den2_r <= den_r;
    end
  end

  // rounding division operands: (2n*turn + 3d) / (6d)
  logic        n_vld_r;
  logic [49:0] nn_r;
  logic [30:0] dd_r;
  logic        nneg_r, zero_r;
  logic [33:0] nmag;

  assign nmag = num_r[33] ? 34'(-num_r) : num_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nn_r   <= 50'({nmag, 1'b0}) * 50'(turn_max_r) + 50'(den2_r) + 50'({den2_r, 1'b0});
      dd_r   <= 31'({den2_r, 2'b0}) + 31'({den2_r, 1'b0});
      nneg_r <= num_r[33];
      zero_r <= (den2_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
      n_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= a_vld && d_vld;
      r_vld_r <= m_vld_r;
      p_vld_r <= r_vld_r;
      s_vld_r <= p_vld_r;
      n_vld_r <= s_vld_r;
    end
  end

  logic        f_vld, f_ovf;
  logic [15:0] f_q;
  logic [1:0]  f_sb;

  fah_div #(.NW(50), .DW(31), .QW(16), .SW(2)) u_fdiv (
    .clk, .rst_n, .en,
    .in_vld(n_vld_r), .in_num(nn_r), .in_den(dd_r), .in_sb({nneg_r, zero_r}),
    .out_vld(f_vld), .out_q(f_q), .out_ovf(f_ovf), .out_sb(f_sb)
  );

  // clamp and sign
  logic [14:0]       f_mag;
  fah_pkg::out_item_t res;
  fah_pkg::out_item_t out_item_r;

  always_comb begin
    f_mag = (f_ovf || f_q > {1'b0, turn_max_r}) ? turn_max_r : f_q[14:0];
    if (f_sb[0]) begin
      res.heading_turn  = '0;
      res.no_rule_fired = 1'b1;
    end else begin
      res.heading_turn  = f_sb[1] ? 16'(-{1'b0, f_mag}) : {1'b0, f_mag};
      res.no_rule_fired = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld |-> (d_vld && a_sb == d_sb))
    else $error("angle and distance dividers out of step");

  a_no_rule_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.no_rule_fired) |-> (out_item.heading_turn == 16'sd0))
    else $error("heading not zero with no rule fired");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (n_vld_r == $past(n_vld_r) && f_vld == $past(f_vld)))
    else $error("pipeline moved during stall");
`endif

endmodule
